[rtl/sqb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqb_pkg: shared types and constants of the sprite quad batcher
// Payload structs, controller/datapath command and status bundles, codes.
// ---------------------------------------------------------------------------
package sqb_pkg;

  localparam int TEX_SLOTS_DEF = 16;
  localparam int MAX_IDX_DEF   = 6144;
  localparam int FLUSH_CNT_W   = 13;
  localparam int SLOT_OUT_W    = 4;
  localparam int IDX_PER_QUAD  = 6;
  localparam int CFG_ADDR_W    = 3;

  // register index, taken from paddr[2]
  localparam logic REG_WHITE_TEX = 1'b0;

  // vertex order within a quad
  localparam logic [1:0] VTX_TL = 2'd0;
  localparam logic [1:0] VTX_TR = 2'd1;
  localparam logic [1:0] VTX_BR = 2'd2;
  localparam logic [1:0] VTX_BL = 2'd3;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] size_w;
    logic signed [31:0] size_h;
    logic [31:0]        color_rgba;
    logic [31:0]        tex_handle;
  } sqb_in_t;

  typedef struct packed {
    logic signed [31:0]     vert_x;
    logic signed [31:0]     vert_y;
    logic signed [31:0]     vert_z;
    logic [SLOT_OUT_W-1:0]  tex_slot;
    logic                   tex_u;
    logic                   tex_v;
    logic [31:0]            vert_color;
    logic                   flush_before;
    logic [FLUSH_CNT_W-1:0] flushed_index_count;
    logic                   last_vertex;
  } sqb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } sqb_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic hit;
    logic alloc;
    logic white;
    logic vert_adv;
  } sqb_cmd_t;

  typedef struct packed {
    logic buf_vld;
    logic white_tex;
    logic at_end;
    logic match;
    logic last_vert;
  } sqb_sts_t;

  function automatic logic signed [31:0] sat_add32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      sat_add32 = s[32] ? SAT_MIN : SAT_MAX;
    end else begin
      sat_add32 = s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[rtl/sqb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqb_ctrl: sprite batcher controller
// Sequences load, slot search and the four vertex requests of each sprite.
// ---------------------------------------------------------------------------
module sqb_ctrl
  import sqb_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire sqb_sts_t sts,
  input  wire logic     out_ready,
  output sqb_cmd_t      cmd,
  output logic          out_valid
);

  sqb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.buf_vld) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_nxt = ST_EMIT;
        if (sts.white_tex) begin
          cmd.white = 1'b1;
        end else if (sts.at_end) begin
          cmd.alloc = 1'b1;
        end else if (sts.match) begin
          cmd.hit = 1'b1;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_EMIT: begin
        out_valid    = 1'b1;
        cmd.vert_adv = out_ready;
        if (out_ready && sts.last_vert) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sqb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sqb_datapath: sprite batcher datapath
// Input buffer, batch counters, texture slot table and vertex formatting.
// ---------------------------------------------------------------------------
module sqb_datapath
  import sqb_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEX_SLOTS_DEF,
  parameter int MAX_INDICES   = MAX_IDX_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire sqb_in_t in_data,
  output logic         in_ready,
  input  wire logic    cfg_we,
  input  wire logic [31:0] cfg_wdata,
  output logic [31:0]  white_id,
  input  wire sqb_cmd_t cmd,
  output sqb_sts_t     sts,
  output sqb_out_t     out_data
);

  localparam int SW  = $clog2(TEXTURE_SLOTS);
  localparam int NSW = $clog2(TEXTURE_SLOTS + 1);
  localparam int IW  = $clog2(MAX_INDICES + IDX_PER_QUAD);

  sqb_in_t            buf_r;
  logic               buf_vld_r;
  logic [31:0]        white_r;
  logic signed [31:0] x_r, y_r, z_r, sx_r, sy_r;
  logic [31:0]        color_r, tex_r;
  logic [IW-1:0]      idx_r;
  logic [NSW-1:0]     ns_r;
  logic [NSW-1:0]     srch_r;
  logic [SW-1:0]      slot_r;
  logic [1:0]         vcnt_r;
  logic               flush_r;
  logic [FLUSH_CNT_W-1:0] fcnt_r;
  logic [31:0]        slot_tab_r [TEXTURE_SLOTS];

  logic                      need_flush;
  logic [IW+FLUSH_CNT_W-1:0] idx_wide;
  logic [SW+SLOT_OUT_W-1:0]  slot_wide;

  assign in_ready  = !buf_vld_r;
  assign white_id  = white_r;
  assign need_flush = (idx_r >= IW'(MAX_INDICES)) || (ns_r >= NSW'(TEXTURE_SLOTS));
  assign idx_wide  = {{FLUSH_CNT_W{1'b0}}, idx_r};
  assign slot_wide = {{SLOT_OUT_W{1'b0}}, slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_vld_r <= 1'b0;
      white_r   <= '0;
      idx_r     <= '0;
      ns_r      <= NSW'(1);
      vcnt_r    <= VTX_TL;
    end else begin
      if (in_valid && in_ready) begin
        buf_vld_r <= 1'b1;
      end else if (cmd.load) begin
        buf_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        white_r <= cfg_wdata;
      end
      if (cmd.load && need_flush) begin
        idx_r <= '0;
        ns_r  <= NSW'(1);
      end
      if (cmd.hit || cmd.alloc || cmd.white) begin
        idx_r <= idx_r + IW'(IDX_PER_QUAD);
      end
      if (cmd.alloc) begin
        ns_r <= ns_r + NSW'(1);
      end
      if (cmd.vert_adv) begin
        vcnt_r <= vcnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_r <= in_data;
    end
    if (cmd.load) begin
      x_r     <= buf_r.pos_x;
      y_r     <= buf_r.pos_y;
      z_r     <= buf_r.pos_z;
      sx_r    <= sat_add32(buf_r.pos_x, buf_r.size_w);
      sy_r    <= sat_add32(buf_r.pos_y, buf_r.size_h);
      color_r <= buf_r.color_rgba;
      tex_r   <= buf_r.tex_handle;
      srch_r  <= NSW'(1);
      flush_r <= need_flush;
      fcnt_r  <= need_flush ? idx_wide[FLUSH_CNT_W-1:0] : '0;
    end
    if (cmd.step) begin
      srch_r <= srch_r + NSW'(1);
    end
    if (cmd.white) begin
      slot_r <= '0;
    end
    if (cmd.hit) begin
      slot_r <= srch_r[SW-1:0];
    end
    if (cmd.alloc) begin
      slot_r                   <= ns_r[SW-1:0];
      slot_tab_r[ns_r[SW-1:0]] <= tex_r;
    end
  end

  always_comb begin
    sts.buf_vld   = buf_vld_r;
    sts.white_tex = (tex_r == white_r);
    sts.at_end    = (srch_r == ns_r);
    sts.match     = (slot_tab_r[srch_r[SW-1:0]] == tex_r);
    sts.last_vert = (vcnt_r == VTX_BL);
  end

  always_comb begin
    out_data.vert_z              = z_r;
    out_data.tex_slot            = slot_wide[SLOT_OUT_W-1:0];
    out_data.vert_color          = color_r;
    out_data.flush_before        = flush_r && (vcnt_r == VTX_TL);
    out_data.flushed_index_count = (vcnt_r == VTX_TL) ? fcnt_r : '0;
    out_data.last_vertex         = (vcnt_r == VTX_BL);
    case (vcnt_r)
      VTX_TL: begin
        out_data.vert_x = x_r;
        out_data.vert_y = y_r;
        out_data.tex_u  = 1'b0;
        out_data.tex_v  = 1'b1;
      end
      VTX_TR: begin
        out_data.vert_x = sx_r;
        out_data.vert_y = y_r;
        out_data.tex_u  = 1'b1;
        out_data.tex_v  = 1'b1;
      end
      VTX_BR: begin
        out_data.vert_x = sx_r;
        out_data.vert_y = sy_r;
        out_data.tex_u  = 1'b1;
        out_data.tex_v  = 1'b0;
      end
      default: begin
        out_data.vert_x = x_r;
        out_data.vert_y = sy_r;
        out_data.tex_u  = 1'b0;
        out_data.tex_v  = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sprite_quad_batcher.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sprite_quad_batcher: sprite to quad vertex setup with texture slot batching
// Emits four corner vertices per sprite; flushes the batch on full index
// count or full slot table and assigns each texture a slot.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       input      in_valid / in_ready       in_data   (sqb_in_t)
//  out      output     out_valid / out_ready     out_data  (sqb_out_t)
//  cfg      input      APB psel/penable/pready   paddr, pwdata, prdata
//
//  A sprite is loaded, searched for in the slot table and then emitted as four
//  vertex requests. The search compares one slot table entry per cycle. An
//  input buffer takes the next sprite while the current one is still
//  emitting. out_ready low holds the current vertex.
//  Synchronous active-low reset; the slot table is not cleared.
// ---------------------------------------------------------------------------
module sprite_quad_batcher
  import sqb_pkg::*;
#(
  parameter int TEXTURE_SLOTS = TEX_SLOTS_DEF,
  parameter int MAX_INDICES   = MAX_IDX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire sqb_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output sqb_out_t                   out_data,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  sqb_cmd_t    cmd;
  sqb_sts_t    sts;
  logic        cfg_we;
  logic [31:0] white_id;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_WHITE_TEX);
  assign prdata = (paddr[2] == REG_WHITE_TEX) ? white_id : '0;

  sqb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .out_ready (out_ready),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  sqb_datapath #(
    .TEXTURE_SLOTS (TEXTURE_SLOTS),
    .MAX_INDICES   (MAX_INDICES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_ready  (in_ready),
    .cfg_we    (cfg_we),
    .cfg_wdata (pwdata),
    .white_id  (white_id),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_buf_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input buffer accepted a request while full");

  a_gap_after_quad: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_vertex |=> !out_valid)
    else $error("vertex request right after the last vertex of a quad");

  a_first_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !out_data.last_vertex && !out_data.tex_u && out_data.tex_v)
    else $error("quad does not start at its first corner");

  a_flush_first_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_vertex |=>
      !out_data.flush_before && (out_data.flushed_index_count == '0))
    else $error("flush report outside the first vertex");
`endif

endmodule
`default_nettype wire

[dv/sprite_quad_batcher_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sprite_quad_batcher_tb: self-checking bench for the sprite quad batcher
// A queue-fed driver pushes sprite requests and a monitor checks every vertex
// against a local model of slot allocation, batch flushes and saturating
// corner sums. Directed corners come first, then random phases with varying
// backpressure and white texture settings.
// ---------------------------------------------------------------------------
module sprite_quad_batcher_tb;
  import sqb_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] WHITE_TEX_ADDR = {REG_WHITE_TEX, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_REG_ADDR = {~REG_WHITE_TEX, 2'b00};
  localparam int DRAIN_CYCLES = TEX_SLOTS_DEF + 14;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  sqb_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  sqb_out_t              out_data;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr     = '0;
  logic [31:0]           pwdata    = '0;
  logic [31:0]           prdata;
  logic                  pready;

  sqb_in_t     sprite_q[$];
  sqb_out_t    vertex_exp_q[$];
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          n_fail        = 0;

  // local copy of batch state
  logic [31:0] slot_ids[TEX_SLOTS_DEF];
  int          slot_next     = 1;
  int          batch_indices = 0;
  logic [31:0] white_tex_id  = '0;
  logic [31:0] tex_pool[24];

  sprite_quad_batcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > longint'(SAT_MAX)) begin
      return SAT_MAX;
    end
    if (s < longint'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return s[31:0];
  endfunction

  task automatic build_quad(input sqb_in_t s);
    sqb_out_t           v;
    logic [3:0]         slot;
    logic               hit;
    logic               flushed;
    logic [12:0]        fcount;
    logic signed [31:0] x_far;
    logic signed [31:0] y_far;
    logic [1:0]         corner;
    flushed = 1'b0;
    fcount  = '0;
    slot    = '0;
    if (batch_indices >= MAX_IDX_DEF || slot_next >= TEX_SLOTS_DEF) begin
      flushed       = 1'b1;
      fcount        = batch_indices[12:0];
      batch_indices = 0;
      slot_next     = 1;
    end
    if (s.tex_handle != white_tex_id) begin
      hit = 1'b0;
      for (int i = 1; i < slot_next; i++) begin
        if (!hit && slot_ids[i] == s.tex_handle) begin
          slot = i[3:0];
          hit  = 1'b1;
        end
      end
      if (!hit && slot_next < TEX_SLOTS_DEF) begin
        slot                = slot_next[3:0];
        slot_ids[slot_next] = s.tex_handle;
        slot_next++;
      end
    end
    x_far = clamp_sum(s.pos_x, s.size_w);
    y_far = clamp_sum(s.pos_y, s.size_h);
    for (int k = 0; k < 4; k++) begin
      corner                = k[1:0];
      v.vert_x              = (corner == VTX_TR || corner == VTX_BR) ? x_far : s.pos_x;
      v.vert_y              = (corner == VTX_BR || corner == VTX_BL) ? y_far : s.pos_y;
      v.vert_z              = s.pos_z;
      v.tex_slot            = slot;
      v.tex_u               = (corner == VTX_TR || corner == VTX_BR);
      v.tex_v               = (corner == VTX_TL || corner == VTX_TR);
      v.vert_color          = s.color_rgba;
      v.flush_before        = (corner == VTX_TL) ? flushed : 1'b0;
      v.flushed_index_count = (corner == VTX_TL) ? fcount : '0;
      v.last_vertex         = (corner == VTX_BL);
      vertex_exp_q.push_back(v);
    end
    batch_indices += IDX_PER_QUAD;
  endtask

  task automatic check_fld(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      n_fail++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sprite_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= sprite_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    sqb_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_quad(in_data);
      end
      if (out_valid && out_ready) begin
        if (vertex_exp_q.size() == 0) begin
          $error("vertex with no request pending");
          n_fail++;
        end else begin
          want = vertex_exp_q.pop_front();
          check_fld("vert_x", want.vert_x, out_data.vert_x);
          check_fld("vert_y", want.vert_y, out_data.vert_y);
          check_fld("vert_z", want.vert_z, out_data.vert_z);
          check_fld("tex_slot", want.tex_slot, out_data.tex_slot);
          check_fld("tex_u", want.tex_u, out_data.tex_u);
          check_fld("tex_v", want.tex_v, out_data.tex_v);
          check_fld("vert_color", want.vert_color, out_data.vert_color);
          check_fld("flush_before", want.flush_before, out_data.flush_before);
          check_fld("flushed_index_count", want.flushed_index_count,
                    out_data.flushed_index_count);
          check_fld("last_vertex", want.last_vertex, out_data.last_vertex);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic reg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr[2] == REG_WHITE_TEX) begin
      white_tex_id = data;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (sprite_q.size() != 0 || in_valid || vertex_exp_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // full-range, small or near the saturation limits
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return 32'($urandom_range(1 << 20)) - 32'h0008_0000;
      2:       return 32'h7fff_ffff - 32'($urandom_range(65535));
      default: return 32'h8000_0000 + 32'($urandom_range(65535));
    endcase
  endfunction

  function automatic sqb_in_t mk_sprite(input logic [31:0] x, input logic [31:0] y,
                                        input logic [31:0] z, input logic [31:0] w,
                                        input logic [31:0] h, input logic [31:0] color,
                                        input logic [31:0] tex);
    sqb_in_t s;
    s.pos_x      = x;
    s.pos_y      = y;
    s.pos_z      = z;
    s.size_w     = w;
    s.size_h     = h;
    s.color_rgba = color;
    s.tex_handle = tex;
    return s;
  endfunction

  function automatic sqb_in_t rand_sprite(input logic [31:0] tex);
    return mk_sprite(rand_coord(), rand_coord(), $urandom, rand_coord(), rand_coord(),
                     $urandom, tex);
  endfunction

  // few_tex keeps the batch under the slot limit so mostly hits are seen
  function automatic logic [31:0] pick_tex(input bit few_tex);
    int r;
    r = $urandom_range(99);
    if (few_tex) begin
      if (r < 20) return white_tex_id;
      if (r < 40) return 32'h0;
      return tex_pool[$urandom_range(2)];
    end
    if (r < 15) return white_tex_id;
    if (r < 30) return $urandom;
    return tex_pool[$urandom_range(23)];
  endfunction

  task automatic run_phase(input int n, input int idle, input int stall, input bit few_tex);
    @(negedge clk);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) sprite_q.push_back(rand_sprite(pick_tex(few_tex)));
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    reg_write(WHITE_TEX_ADDR, 32'h0);
    reg_write(SPARE_REG_ADDR, $urandom);

    @(negedge clk);
    sprite_q.push_back(mk_sprite(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0));
    sprite_q.push_back(mk_sprite(SAT_MAX, SAT_MIN, SAT_MAX, SAT_MAX, SAT_MIN,
                                 32'hffff_ffff, 32'h1));
    sprite_q.push_back(mk_sprite(SAT_MIN, SAT_MAX, SAT_MIN, 32'hffff_ffff, 32'h1,
                                 32'h1234_5678, 32'h1));
    sprite_q.push_back(mk_sprite(32'hffff_ffff, 32'h0001_0000, 32'hffff_ffff, 32'h1,
                                 32'hfffe_0000, 32'h8040_20ff, 32'hffff_ffff));
    // fill the remaining slots, then force a slot-full flush
    for (int i = 0; i < TEX_SLOTS_DEF - 3; i++) begin
      sprite_q.push_back(rand_sprite(32'h100 + i));
    end
    sprite_q.push_back(rand_sprite(32'h1));
    sprite_q.push_back(rand_sprite(32'h0));
    wait_drained();

    // few textures, back to back: long batch of slot hits
    foreach (tex_pool[i]) tex_pool[i] = $urandom;
    reg_write(WHITE_TEX_ADDR, 32'hffff_ffff);
    run_phase(120, 0, 0, 1'b1);

    foreach (tex_pool[i]) tex_pool[i] = $urandom;
    reg_write(WHITE_TEX_ADDR, $urandom);
    run_phase(113, 87, 0, 1'b0);

    reg_write(WHITE_TEX_ADDR, 32'h0);
    run_phase(113, 0, 87, 1'b0);

    reg_write(WHITE_TEX_ADDR, tex_pool[0]);
    run_phase(113, 23, 23, 1'b0);

    if (n_fail == 0 && vertex_exp_q.size() == 0) begin
      $display("PASS sprite_quad_batcher");
    end else begin
      $display("FAIL sprite_quad_batcher");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL sprite_quad_batcher");
    $finish;
  end

endmodule

[sprite_quad_batcher.f]
rtl/sqb_pkg.sv
rtl/sqb_ctrl.sv
rtl/sqb_datapath.sv
rtl/sprite_quad_batcher.sv
dv/sprite_quad_batcher_tb.sv
